@@ src/rlap_pkg.sv @@
// Shared constants, types and state codes of the ranked-list average precision core.
// No dependencies; compile before every other file in src.
package rlap_pkg;

    localparam int MAX_LIST  = 1024;
    localparam int FRAC_BITS = 16;

    localparam int LEN_W     = 11;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CNT_W     = $clog2(MAX_LIST) + 1;
    localparam int SUM_W     = CNT_W + FRAC_BITS;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int REM_W     = CNT_W + 1;
    localparam int STEP_W    = $clog2(FX_W + 1);
    localparam int OUT_BITS  = 2 * CNT_W + 3 * FX_W;
    localparam int TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FX_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [0:0] {
        REG_LIST_LENGTH = 1'b0,
        REG_POSSIBLE_POS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [CNT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            busy;
        logic [FX_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ src/rlap_div.sv @@
// Bit-serial restoring divider: saturated fixed-point ratio num / den, one quotient bit a cycle.
// Depends on rlap_pkg.
module rlap_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  rlap_pkg::div_req_t req,
    output rlap_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [rlap_pkg::STEP_W-1:0]   step_reg;
    logic [rlap_pkg::STEP_W-1:0]   step_next;
    logic [rlap_pkg::REM_W-1:0]    rem_reg;
    logic [rlap_pkg::REM_W-1:0]    rem_next;
    logic [rlap_pkg::FX_W-1:0]     quot_reg;
    logic [rlap_pkg::FX_W-1:0]     quot_next;
    logic [rlap_pkg::CNT_W-1:0]    den_reg;
    logic [rlap_pkg::CNT_W-1:0]    den_next;
    logic                          trial_ge;
    logic [rlap_pkg::REM_W-1:0]    rem_sub;
    logic                          sat;

    assign trial_ge = rem_reg >= {1'b0, den_reg};
    assign rem_sub  = trial_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    // quotient reaches 2.0 or more: saturate without iterating
    assign sat = req.num >= {{(rlap_pkg::SUM_W - rlap_pkg::REM_W){1'b0}}, req.den, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            den_next = req.den;
            step_next = '0;
            if (sat)
            begin
                busy_next = 1'b0;
                quot_next = rlap_pkg::ONE_FX;
            end
            else
            begin
                busy_next = 1'b1;
                rem_next  = req.num[rlap_pkg::REM_W-1:0];
                quot_next = '0;
            end
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[rlap_pkg::FX_W-2:0], trial_ge};
            rem_next  = {rem_sub[rlap_pkg::REM_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == rlap_pkg::STEP_W'(rlap_pkg::FX_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = (quot_reg > rlap_pkg::ONE_FX) ? rlap_pkg::ONE_FX : quot_reg;

endmodule

@@ src/ranked_list_average_precision_core.sv @@
// Top level of the ranked-list average precision core: counters, sequencer, output register.
// Depends on rlap_pkg and rlap_div.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata): one relevance bit per ranked result,
//   in rank order, in s_tdata[0]. Output stream (m_tvalid/m_tready/m_tdata/m_tlast/
//   m_tuser): one result per request with rank, hits, precision, recall and average
//   precision; m_tlast marks the last rank of a list, m_tuser flags a zero divisor.
//   Configuration: cfg_we/cfg_index/cfg_data write list_length (index 0) and
//   possible_positives (index 1); write only while no request is in flight.
//   Sequencing: an accepted request runs one divider pass for precision and recall, then
//   loads the output register; a last rank with a nonzero divisor takes a second pass
//   for average precision, which ends at once if that ratio saturates. Each pass is a
//   bit-serial divider, one quotient bit a cycle; precision and recall share a pass on
//   two divider instances. The core takes no new request while one runs; the next is
//   taken once the previous result is in the output register, even while it waits.
//   Reset: counters and precision sum clear, list_length returns to 100 and
//   possible_positives to 0. A stalled receiver holds the result and, once the core
//   finishes the following request, blocks s_tready until the register frees.
module ranked_list_average_precision_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] is_relevant
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // rank, hits_so_far, precision, recall, average_precision from bit 0, zero-filled
    output logic [rlap_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast,   // is_last
    output logic                          m_tuser,   // zero_divisor
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [rlap_pkg::CFG_W-1:0]    cfg_data
);

    rlap_pkg::state_t               state_reg;
    rlap_pkg::state_t               state_next;

    logic [rlap_pkg::LEN_W-1:0]     list_length_reg;
    logic [rlap_pkg::POS_W-1:0]     possible_positives_reg;
    logic [rlap_pkg::CNT_W-1:0]     rank_count_reg;
    logic [rlap_pkg::CNT_W-1:0]     hit_count_reg;
    logic [rlap_pkg::SUM_W-1:0]     sum_reg;

    logic                           rel_reg;
    logic [rlap_pkg::CNT_W-1:0]     rank_reg;
    logic [rlap_pkg::CNT_W-1:0]     hits_reg;
    logic                           last_reg;
    logic                           zdiv_reg;
    logic [rlap_pkg::CNT_W-1:0]     divisor_reg;
    logic [rlap_pkg::FX_W-1:0]      prec_reg;
    logic [rlap_pkg::FX_W-1:0]      rec_reg;
    logic [rlap_pkg::FX_W-1:0]      ap_reg;

    logic                           m_tvalid_reg;
    logic [rlap_pkg::TDATA_W-1:0]   m_tdata_reg;
    logic                           m_tlast_reg;
    logic                           m_tuser_reg;

    logic [rlap_pkg::CNT_W-1:0]     eff_len;
    logic [rlap_pkg::CNT_W-1:0]     divisor;
    logic [rlap_pkg::CNT_W-1:0]     rank_new;
    logic [rlap_pkg::CNT_W-1:0]     hits_new;
    logic                           in_accept;
    logic                           pass1_done;
    logic                           pass2_done;
    logic                           out_load;

    rlap_pkg::div_req_t             req_a;
    rlap_pkg::div_req_t             req_b;
    rlap_pkg::div_rsp_t             rsp_a;
    rlap_pkg::div_rsp_t             rsp_b;

    rlap_div u_div_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_a),
        .rsp   (rsp_a)
    );

    rlap_div u_div_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_b),
        .rsp   (rsp_b)
    );

    always_comb
    begin
        if (list_length_reg == '0)
        begin
            eff_len = rlap_pkg::CNT_W'(1);
        end
        else if (32'(list_length_reg) > rlap_pkg::MAX_LIST)
        begin
            eff_len = rlap_pkg::CNT_W'(rlap_pkg::MAX_LIST);
        end
        else
        begin
            eff_len = rlap_pkg::CNT_W'(list_length_reg);
        end
        if (32'(possible_positives_reg) < 32'(eff_len))
        begin
            divisor = rlap_pkg::CNT_W'(possible_positives_reg);
        end
        else
        begin
            divisor = eff_len;
        end
    end

    assign rank_new = rank_count_reg + 1'b1;
    assign hits_new = hit_count_reg + rlap_pkg::CNT_W'(s_tdata[0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlap_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rlap_pkg::ST_START1;
                end
            end
            rlap_pkg::ST_START1:
            begin
                state_next = rlap_pkg::ST_WAIT1;
            end
            rlap_pkg::ST_WAIT1:
            begin
                if (!rsp_a.busy && !rsp_b.busy)
                begin
                    state_next = (last_reg && !zdiv_reg) ? rlap_pkg::ST_START2
                                                         : rlap_pkg::ST_DONE;
                end
            end
            rlap_pkg::ST_START2:
            begin
                state_next = rlap_pkg::ST_WAIT2;
            end
            rlap_pkg::ST_WAIT2:
            begin
                if (!rsp_a.busy)
                begin
                    state_next = rlap_pkg::ST_DONE;
                end
            end
            rlap_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = rlap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlap_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready    = (state_reg == rlap_pkg::ST_IDLE);
        pass1_done  = (state_reg == rlap_pkg::ST_WAIT1) && !rsp_a.busy && !rsp_b.busy;
        pass2_done  = (state_reg == rlap_pkg::ST_WAIT2) && !rsp_a.busy;
        out_load    = (state_reg == rlap_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
        req_a.start = (state_reg == rlap_pkg::ST_START1) || (state_reg == rlap_pkg::ST_START2);
        req_b.start = (state_reg == rlap_pkg::ST_START1);
        if (state_reg == rlap_pkg::ST_START2)
        begin
            req_a.num = sum_reg;
            req_a.den = divisor_reg;
        end
        else
        begin
            req_a.num = rlap_pkg::SUM_W'(hits_reg);
            req_a.den = rank_reg;
        end
        req_b.num = rlap_pkg::SUM_W'(hits_reg);
        req_b.den = divisor_reg;
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= rlap_pkg::ST_IDLE;
            list_length_reg        <= rlap_pkg::LEN_W'(100);
            possible_positives_reg <= '0;
            rank_count_reg         <= '0;
            hit_count_reg          <= '0;
            sum_reg                <= '0;
            m_tvalid_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (rlap_pkg::cfg_reg_t'(cfg_index))
                    rlap_pkg::REG_LIST_LENGTH:
                    begin
                        list_length_reg <= cfg_data[rlap_pkg::LEN_W-1:0];
                    end
                    rlap_pkg::REG_POSSIBLE_POS:
                    begin
                        possible_positives_reg <= cfg_data[rlap_pkg::POS_W-1:0];
                    end
                    default:
                    begin
                        list_length_reg <= list_length_reg;
                    end
                endcase
            end
            if (pass1_done && rel_reg)
            begin
                sum_reg <= sum_reg + rlap_pkg::SUM_W'(rsp_a.quot);
            end
            if (out_load)
            begin
                if (last_reg)
                begin
                    rank_count_reg <= '0;
                    hit_count_reg  <= '0;
                    sum_reg        <= '0;
                end
                else
                begin
                    rank_count_reg <= rank_reg;
                    hit_count_reg  <= hits_reg;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rel_reg     <= s_tdata[0];
            rank_reg    <= rank_new;
            hits_reg    <= hits_new;
            last_reg    <= (rank_new >= eff_len);
            zdiv_reg    <= (divisor == '0);
            divisor_reg <= divisor;
        end
        if (pass1_done)
        begin
            prec_reg <= rsp_a.quot;
            rec_reg  <= zdiv_reg ? '0 : rsp_b.quot;
            ap_reg   <= '0;
        end
        if (pass2_done)
        begin
            ap_reg <= rsp_a.quot;
        end
        if (out_load)
        begin
            m_tdata_reg <= rlap_pkg::TDATA_W'({ap_reg, rec_reg, prec_reg, hits_reg, rank_reg});
            m_tlast_reg <= last_reg;
            m_tuser_reg <= zdiv_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_ready_idle_dividers: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!rsp_a.busy && !rsp_b.busy))
        else $error("request taken while a divider runs");

    a_output_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == rlap_pkg::ST_DONE))
        else $error("result presented outside the done state");

    a_hits_within_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlap_pkg::ST_DONE) |-> (hits_reg <= rank_reg))
        else $error("hit count exceeds rank");

    a_prec_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlap_pkg::ST_DONE) |-> (prec_reg <= rlap_pkg::ONE_FX))
        else $error("precision above one");

endmodule
